>>> hdl/srrw_pkg.sv
// Shared types and constants for the selective-reject receive window.
// No dependencies; imported by every module of the block.
package srrw_pkg;

  localparam int SEQ_W    = 32;
  localparam int HANDLE_W = 32;
  localparam int LEN_W    = 11;
  localparam int KIND_W   = 2;
  localparam int TYPE_W   = 8;
  localparam int CFG_W    = 5;

  // largest window the register can express
  localparam int WIN_CAP = (1 << CFG_W) - 1;

  localparam logic [CFG_W-1:0]  WIN_RESET = 5'd16;
  localparam logic [TYPE_W-1:0] TYPE_DATA = 8'd3;
  localparam logic [SEQ_W-1:0]  NONE_SENT = '1;

  localparam logic [KIND_W-1:0] KIND_DELIVER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RR      = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SREJ    = 2'd2;

  // remainder unit: one hex digit per step
  localparam int DIGIT_W   = 4;
  localparam int MOD_STEPS = SEQ_W / DIGIT_W;
  localparam int MCNT_W    = $clog2(MOD_STEPS);

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SEQ_W-1:0]    seq;
    logic [SEQ_W-1:0]    ctr;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } res_t;

  typedef struct packed {
    logic latch;         // capture the input word
    logic deliver_item;  // deliver the captured frame
    logic rr;            // send RR
    logic mod_start;     // start slot index computation
    logic ptr_load;      // load slot pointer from remainder
    logic ptr_plus;      // ... advanced by one slot
    logic store_srej;    // store frame, SREJ once
    logic flush_step;    // deliver the stored frame at the pointer
    logic flush_end;     // closing control word of a flush
    logic finish;        // push out the held word as last
  } dp_cmd_t;

  typedef struct packed {
    logic ok_data;
    logic eq;
    logic gt;
    logic mode;
    logic mod_done;
    logic hit;
  } dp_stat_t;

  function automatic logic [CFG_W-1:0] wrap_inc(input logic [CFG_W-1:0] v,
                                                input logic [CFG_W-1:0] w);
    logic [CFG_W:0] p1;
    p1 = {1'b0, v} + (CFG_W+1)'(1);
    if (p1 == {1'b0, w}) begin
      return '0;
    end
    return p1[CFG_W-1:0];
  endfunction

endpackage

>>> hdl/srrw_mod.sv
// Iterative remainder unit: sequence number modulo the window, four bits a step.
// Depends on srrw_pkg.
module srrw_mod
  import srrw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SEQ_W-1:0] dividend_i,
  input  logic [CFG_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CFG_W-1:0] rem_o
);

  localparam int VAL_W = CFG_W + DIGIT_W;

  logic              run_q, done_q;
  logic [MCNT_W-1:0] cnt_q;
  logic [SEQ_W-1:0]  sh_q;
  logic [CFG_W-1:0]  rem_q;
  logic [VAL_W-1:0]  acc;
  logic [VAL_W-1:0]  dsh;

  // rem < divisor, so acc < 16*divisor: restoring subtract of 8d, 4d, 2d, d
  always_comb begin
    acc = {rem_q, sh_q[SEQ_W-1 -: DIGIT_W]};
    dsh = '0;
    for (int k = DIGIT_W - 1; k >= 0; k--) begin
      dsh = VAL_W'(divisor_i) << k;
      if (acc >= dsh) begin
        acc = acc - dsh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + MCNT_W'(1);
      if (cnt_q == MCNT_W'(MOD_STEPS - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      sh_q  <= sh_q << DIGIT_W;
      rem_q <= acc[CFG_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

>>> hdl/srrw_dp.sv
// Datapath: window state, slot store, result hold and output registers.
// Depends on srrw_pkg and srrw_mod.
module srrw_dp
  import srrw_pkg::*;
#(
  parameter int WINDOW_MAX  = 16,
  parameter int MAX_PAYLOAD = 1400
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                checksum_ok_i,
  input  logic [TYPE_W-1:0]   frame_type_i,
  input  logic [SEQ_W-1:0]    seq_num_i,
  input  logic [HANDLE_W-1:0] payload_handle_i,
  input  logic [LEN_W-1:0]    payload_len_i,
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  output logic                res_valid_o,
  output logic [KIND_W-1:0]   out_kind_o,
  output logic [SEQ_W-1:0]    out_seq_o,
  output logic [SEQ_W-1:0]    ctrl_counter_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [LEN_W-1:0]    out_len_o,
  output logic                last_o
);

  // slots beyond what the register can select are never touched
  localparam int SLOTS      = (WINDOW_MAX < WIN_CAP) ? WINDOW_MAX : WIN_CAP;
  localparam int SIDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_DEPTH = 1 << SIDX_W;
  localparam int WALK_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [CFG_W-1:0]  SLOTS_C   = CFG_W'(SLOTS);
  localparam logic [WALK_W-1:0] WALK_LIM  = WALK_W'(WINDOW_MAX - 1);
  localparam logic [LEN_W-1:0]  LEN_SAT   = LEN_W'(MAX_PAYLOAD);

  logic [CFG_W-1:0]    wsize_q, w_eff;
  logic                mode_q;
  logic [SEQ_W-1:0]    exp_q, high_q, ctr_q, last_srej_q;
  logic [SIDX_W-1:0]   ptr_q;
  logic [WALK_W-1:0]   walk_q;

  logic                item_ok_q;
  logic [SEQ_W-1:0]    item_seq_q;
  logic [HANDLE_W-1:0] item_handle_q;
  logic [LEN_W-1:0]    item_len_q;

  logic                slot_valid_q [SLOT_DEPTH];
  logic [SEQ_W-1:0]    slot_seq_q [SLOT_DEPTH];
  logic [HANDLE_W-1:0] slot_handle_q [SLOT_DEPTH];
  logic [LEN_W-1:0]    slot_len_q [SLOT_DEPTH];

  logic                pend_valid_q, out_valid_q, out_last_q;
  res_t                pend_q, out_q, new_res;
  logic                gen, hole, srej_new, ctrl_sent;
  logic                mod_done;
  logic [CFG_W-1:0]    rem, ptr_next, ptr_first;
  logic [LEN_W-1:0]    len_sat;

  // effective window: 0 acts as 1, clipped to the slot count
  always_comb begin
    if (wsize_q == '0) begin
      w_eff = CFG_W'(1);
    end else if (wsize_q > SLOTS_C) begin
      w_eff = SLOTS_C;
    end else begin
      w_eff = wsize_q;
    end
  end

  srrw_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.mod_start),
    .dividend_i (item_seq_q),
    .divisor_i  (w_eff),
    .done_o     (mod_done),
    .rem_o      (rem)
  );

  assign len_sat   = (32'(payload_len_i) > 32'(MAX_PAYLOAD)) ? LEN_SAT : payload_len_i;
  assign ptr_next  = wrap_inc(CFG_W'(ptr_q), w_eff);
  assign ptr_first = wrap_inc(rem, w_eff);
  assign hole      = (exp_q <= high_q);
  assign srej_new  = (last_srej_q != exp_q);

  assign stat_o.ok_data  = item_ok_q;
  assign stat_o.eq       = (item_seq_q == exp_q);
  assign stat_o.gt       = (item_seq_q > exp_q);
  assign stat_o.mode     = mode_q;
  assign stat_o.mod_done = mod_done;
  assign stat_o.hit      = slot_valid_q[ptr_q] && (slot_seq_q[ptr_q] == exp_q) &&
                           (walk_q < WALK_LIM);

  // next result word, if any
  always_comb begin
    gen       = 1'b0;
    ctrl_sent = 1'b0;
    new_res   = '0;
    if (cmd_i.deliver_item) begin
      gen            = 1'b1;
      new_res.kind   = KIND_DELIVER;
      new_res.seq    = item_seq_q;
      new_res.handle = item_handle_q;
      new_res.len    = item_len_q;
    end else if (cmd_i.flush_step) begin
      gen            = 1'b1;
      new_res.kind   = KIND_DELIVER;
      new_res.seq    = slot_seq_q[ptr_q];
      new_res.handle = slot_handle_q[ptr_q];
      new_res.len    = slot_len_q[ptr_q];
    end else if (cmd_i.rr || (cmd_i.flush_end && !hole)) begin
      gen          = 1'b1;
      ctrl_sent    = 1'b1;
      new_res.kind = KIND_RR;
      new_res.seq  = exp_q;
      new_res.ctr  = ctr_q;
    end else if ((cmd_i.store_srej || (cmd_i.flush_end && hole)) && srej_new) begin
      gen          = 1'b1;
      ctrl_sent    = 1'b1;
      new_res.kind = KIND_SREJ;
      new_res.seq  = exp_q;
      new_res.ctr  = ctr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsize_q      <= WIN_RESET;
      mode_q       <= 1'b0;
      exp_q        <= '0;
      high_q       <= '0;
      ctr_q        <= '0;
      last_srej_q  <= NONE_SENT;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < SLOT_DEPTH; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        wsize_q <= cfg_wdata_i;
      end
      if (ctrl_sent) begin
        ctr_q <= ctr_q + SEQ_W'(1);
      end
      if (cmd_i.deliver_item) begin
        exp_q <= exp_q + SEQ_W'(1);
        if (!mode_q) begin
          high_q <= exp_q;
        end else begin
          last_srej_q <= NONE_SENT;
        end
      end
      if (cmd_i.store_srej) begin
        slot_valid_q[ptr_q] <= 1'b1;
        if (!mode_q || (item_seq_q > high_q)) begin
          high_q <= item_seq_q;
        end
        if (srej_new) begin
          last_srej_q <= exp_q;
        end
        mode_q <= 1'b1;
      end
      if (cmd_i.flush_step) begin
        slot_valid_q[ptr_q] <= 1'b0;
        exp_q               <= exp_q + SEQ_W'(1);
      end
      if (cmd_i.flush_end) begin
        mode_q <= hole;
        if (hole && srej_new) begin
          last_srej_q <= exp_q;
        end
      end
      // one-word hold so the last flag lands on the right word
      if (gen) begin
        pend_valid_q <= 1'b1;
        out_valid_q  <= pend_valid_q;
      end else if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
        out_valid_q  <= pend_valid_q;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_ok_q     <= checksum_ok_i && (frame_type_i == TYPE_DATA);
      item_seq_q    <= seq_num_i;
      item_handle_q <= payload_handle_i;
      item_len_q    <= len_sat;
    end
    if (cmd_i.ptr_load) begin
      ptr_q  <= cmd_i.ptr_plus ? ptr_first[SIDX_W-1:0] : rem[SIDX_W-1:0];
      walk_q <= '0;
    end else if (cmd_i.flush_step) begin
      ptr_q  <= ptr_next[SIDX_W-1:0];
      walk_q <= walk_q + WALK_W'(1);
    end
    if (cmd_i.store_srej) begin
      slot_seq_q[ptr_q]    <= item_seq_q;
      slot_handle_q[ptr_q] <= item_handle_q;
      slot_len_q[ptr_q]    <= item_len_q;
    end
    if (gen) begin
      pend_q <= new_res;
    end
    if (gen || cmd_i.finish) begin
      out_q      <= pend_q;
      out_last_q <= cmd_i.finish;
    end
  end

  assign res_valid_o    = out_valid_q;
  assign out_kind_o     = out_q.kind;
  assign out_seq_o      = out_q.seq;
  assign ctrl_counter_o = out_q.ctr;
  assign out_handle_o   = out_q.handle;
  assign out_len_o      = out_q.len;
  assign last_o         = out_last_q;

endmodule

>>> hdl/srrw_ctrl.sv
// Controller state machine: sequences one frame through the datapath.
// Depends on srrw_pkg.
module srrw_ctrl
  import srrw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_RR     = 7'b0000100,
    S_MOD    = 7'b0001000,
    S_STORE  = 7'b0010000,
    S_FLUSH  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   flush_q, flush_d;

  always_comb begin
    state_d = state_q;
    flush_d = flush_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat_i.ok_data) begin
          state_d = S_IDLE;
        end else if (stat_i.eq) begin
          cmd_o.deliver_item = 1'b1;
          if (!stat_i.mode) begin
            state_d = S_RR;
          end else begin
            cmd_o.mod_start = 1'b1;
            flush_d         = 1'b1;
            state_d         = S_MOD;
          end
        end else if (stat_i.gt) begin
          cmd_o.mod_start = 1'b1;
          flush_d         = 1'b0;
          state_d         = S_MOD;
        end else begin
          cmd_o.rr = 1'b1;
          state_d  = S_FINISH;
        end
      end
      S_RR: begin
        cmd_o.rr = 1'b1;
        state_d  = S_FINISH;
      end
      S_MOD: begin
        if (stat_i.mod_done) begin
          cmd_o.ptr_load = 1'b1;
          cmd_o.ptr_plus = flush_q;
          state_d        = flush_q ? S_FLUSH : S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store_srej = 1'b1;
        state_d          = S_FINISH;
      end
      S_FLUSH: begin
        if (stat_i.hit) begin
          cmd_o.flush_step = 1'b1;
        end else begin
          cmd_o.flush_end = 1'b1;
          state_d         = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      flush_q <= flush_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

>>> hdl/selective_reject_receive_window.sv
// Top level of the selective-reject receive window.
// Depends on srrw_pkg, srrw_ctrl, srrw_dp (which holds srrw_mod).
//
//   channel   | handshake            | payload
//   ----------+----------------------+--------------------------------------------
//   frame in  | start, busy          | checksum_ok_i, frame_type_i, seq_num_i,
//             |                      | payload_handle_i, payload_len_i
//   config    | cfg_we_i             | cfg_wdata_i (window_size)
//   result    | res_valid_o (strobe) | out_kind_o, out_seq_o, ctrl_counter_o,
//             |                      | out_handle_o, out_len_o, last_o
//
// A word is taken when start is high and busy is low; one frame is in work at
// a time. A frame that needs its slot index (stored out of order, or closing a
// gap) runs the 8-step remainder unit; a frame that closes a gap then starts
// the flush walk, which delivers the stored frames that follow it in order.
// Result words come out one per cycle, one word behind the work, on a strobe;
// the receiver cannot stall them. Reset is asynchronous and needs no clearing
// pass: slot valid bits are flops cleared at once.
module selective_reject_receive_window
  import srrw_pkg::*;
#(
  parameter int WINDOW_MAX  = 16,
  parameter int MAX_PAYLOAD = 1400
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // frame descriptor
  input  logic                start,
  output logic                busy,
  input  logic                checksum_ok_i,
  input  logic [TYPE_W-1:0]   frame_type_i,
  input  logic [SEQ_W-1:0]    seq_num_i,
  input  logic [HANDLE_W-1:0] payload_handle_i,
  input  logic [LEN_W-1:0]    payload_len_i,
  // window_size register
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  // result words
  output logic                res_valid_o,
  output logic [KIND_W-1:0]   out_kind_o,
  output logic [SEQ_W-1:0]    out_seq_o,
  output logic [SEQ_W-1:0]    ctrl_counter_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [LEN_W-1:0]    out_len_o,
  output logic                last_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller only sees start in idle, so start & !busy is the accept
  srrw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  srrw_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .checksum_ok_i    (checksum_ok_i),
    .frame_type_i     (frame_type_i),
    .seq_num_i        (seq_num_i),
    .payload_handle_i (payload_handle_i),
    .payload_len_i    (payload_len_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .res_valid_o      (res_valid_o),
    .out_kind_o       (out_kind_o),
    .out_seq_o        (out_seq_o),
    .ctrl_counter_o   (ctrl_counter_o),
    .out_handle_o     (out_handle_o),
    .out_len_o        (out_len_o),
    .last_o           (last_o)
  );

endmodule

>>> verif/tb_selective_reject_receive_window.sv
// Self-checking testbench for the selective-reject receive window.
// Depends on srrw_pkg and selective_reject_receive_window; a scoreboard class
// predicts every result word and checks the words the block puts out.
module tb_selective_reject_receive_window
  import srrw_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_COUNT   = 16;    // window slots built into the block
  localparam int MAX_LEN      = 1400;  // payload length saturates here
  localparam int DRAIN_CYCLES = 40;    // longest frame: remainder unit plus a 16-word flush
  localparam int PHASE_FRAMES = 12;    // data frames per window setting

  // One predicted result word.
  typedef struct {
    bit [KIND_W-1:0]   kind;
    bit [SEQ_W-1:0]    seq;
    bit [SEQ_W-1:0]    ctr;
    bit [HANDLE_W-1:0] handle;
    bit [LEN_W-1:0]    len;
    bit                last;
  } rx_word_t;

  // Scoreboard: carries its own copy of the receive window state, turns each
  // accepted frame into the words it should produce, and checks the block's
  // output words in order against them.
  class rx_window_scoreboard;
    bit [CFG_W-1:0]    window_reg;
    bit                buffering;
    bit [SEQ_W-1:0]    exp_seq;
    bit [SEQ_W-1:0]    high_seq;
    bit [SEQ_W-1:0]    ctrl_count;
    bit [SEQ_W-1:0]    last_srej;
    bit                slot_valid  [SLOT_COUNT];
    bit [SEQ_W-1:0]    slot_seq    [SLOT_COUNT];
    bit [HANDLE_W-1:0] slot_handle [SLOT_COUNT];
    bit [LEN_W-1:0]    slot_len    [SLOT_COUNT];
    rx_word_t          expected_words[$];
    int unsigned       words_checked;
    int unsigned       mismatches;

    function new();
      window_reg = WIN_RESET;
      buffering  = 1'b0;
      exp_seq    = '0;
      high_seq   = '0;
      ctrl_count = '0;
      last_srej  = NONE_SENT;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      words_checked = 0;
      mismatches    = 0;
    endfunction

    // window 0 acts as 1, anything above the slot count as the slot count
    function int unsigned slot_index(bit [SEQ_W-1:0] s);
      int unsigned span;
      span = (window_reg == 0) ? 1 : (window_reg > SLOT_COUNT) ? SLOT_COUNT : window_reg;
      return (s % span) % SLOT_COUNT;
    endfunction

    function void push_word(bit [KIND_W-1:0] kind, bit [SEQ_W-1:0] seq,
                            bit [SEQ_W-1:0] ctr, bit [HANDLE_W-1:0] handle,
                            bit [LEN_W-1:0] len);
      rx_word_t w;
      w.kind = kind; w.seq = seq; w.ctr = ctr;
      w.handle = handle; w.len = len; w.last = 1'b0;
      expected_words.push_back(w);
    endfunction

    function void send_control(bit [KIND_W-1:0] kind);
      push_word(kind, exp_seq, ctrl_count, '0, '0);
      ctrl_count++;
    endfunction

    // one SREJ per hole: repeated requests for the same sequence are dropped
    function void srej_once();
      if (last_srej != exp_seq) begin
        send_control(KIND_SREJ);
        last_srej = exp_seq;
      end
    endfunction

    function void store_frame(bit [SEQ_W-1:0] seq, bit [HANDLE_W-1:0] handle,
                              bit [LEN_W-1:0] len);
      int unsigned i;
      i = slot_index(seq);
      slot_seq[i] = seq; slot_handle[i] = handle; slot_len[i] = len;
      slot_valid[i] = 1'b1;
    endfunction

    // Called once per accepted frame descriptor.
    function void take_frame(bit ok, bit [TYPE_W-1:0] ftype, bit [SEQ_W-1:0] seq,
                             bit [HANDLE_W-1:0] handle, bit [LEN_W-1:0] len);
      int unsigned first;
      int unsigned i;
      int          walked;
      first = expected_words.size();
      if (len > MAX_LEN) len = LEN_W'(MAX_LEN);
      if (!ok || ftype != TYPE_DATA) return;

      if (!buffering) begin
        if (seq == exp_seq) begin
          push_word(KIND_DELIVER, seq, '0, handle, len);
          high_seq = exp_seq;
          exp_seq++;
          send_control(KIND_RR);
        end else if (seq > exp_seq) begin
          store_frame(seq, handle, len);
          high_seq = seq;
          srej_once();
          buffering = 1'b1;
        end else begin
          send_control(KIND_RR);
        end
      end else begin
        if (seq == exp_seq) begin
          last_srej = NONE_SENT;
          push_word(KIND_DELIVER, seq, '0, handle, len);
          exp_seq++;
          // walk the slots; the arriving frame counts toward the flush bound
          walked = 0;
          while (walked < SLOT_COUNT - 1) begin
            i = slot_index(exp_seq);
            if (!slot_valid[i] || slot_seq[i] != exp_seq) break;
            push_word(KIND_DELIVER, slot_seq[i], '0, slot_handle[i], slot_len[i]);
            slot_valid[i] = 1'b0;
            exp_seq++;
            walked++;
          end
          if (exp_seq <= high_seq) begin
            srej_once();
            buffering = 1'b1;
          end else begin
            send_control(KIND_RR);
            buffering = 1'b0;
          end
        end else if (seq > exp_seq) begin
          store_frame(seq, handle, len);
          if (seq > high_seq) high_seq = seq;
          srej_once();
        end else begin
          send_control(KIND_RR);
        end
      end

      if (expected_words.size() > first) expected_words[$].last = 1'b1;
    endfunction

    // Called for every result strobe.
    function void check_word(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] seq,
                             logic [SEQ_W-1:0] ctr, logic [HANDLE_W-1:0] handle,
                             logic [LEN_W-1:0] len, logic last);
      rx_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: kind %0d seq %h", kind, seq);
        mismatches++;
        return;
      end
      w = expected_words.pop_front();
      words_checked++;
      if (kind !== w.kind) begin
        $error("out_kind: expected %0d, got %0d", w.kind, kind);
        mismatches++;
      end
      if (seq !== w.seq) begin
        $error("out_seq: expected %h, got %h", w.seq, seq);
        mismatches++;
      end
      if (ctr !== w.ctr) begin
        $error("ctrl_counter: expected %h, got %h", w.ctr, ctr);
        mismatches++;
      end
      if (handle !== w.handle) begin
        $error("out_handle: expected %h, got %h", w.handle, handle);
        mismatches++;
      end
      if (len !== w.len) begin
        $error("out_len: expected %0d, got %0d", w.len, len);
        mismatches++;
      end
      if (last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                checksum_ok_i;
  logic [TYPE_W-1:0]   frame_type_i;
  logic [SEQ_W-1:0]    seq_num_i;
  logic [HANDLE_W-1:0] payload_handle_i;
  logic [LEN_W-1:0]    payload_len_i;
  logic                cfg_we_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                res_valid_o;
  logic [KIND_W-1:0]   out_kind_o;
  logic [SEQ_W-1:0]    out_seq_o;
  logic [SEQ_W-1:0]    ctrl_counter_o;
  logic [HANDLE_W-1:0] out_handle_o;
  logic [LEN_W-1:0]    out_len_o;
  logic                last_o;

  rx_window_scoreboard sb;
  int burst_left;      // words left in the current sender burst
  int data_frames;
  int ignored_frames;

  selective_reject_receive_window #(
    .WINDOW_MAX  (SLOT_COUNT),
    .MAX_PAYLOAD (MAX_LEN)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .checksum_ok_i    (checksum_ok_i),
    .frame_type_i     (frame_type_i),
    .seq_num_i        (seq_num_i),
    .payload_handle_i (payload_handle_i),
    .payload_len_i    (payload_len_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .res_valid_o      (res_valid_o),
    .out_kind_o       (out_kind_o),
    .out_seq_o        (out_seq_o),
    .ctrl_counter_o   (ctrl_counter_o),
    .out_handle_o     (out_handle_o),
    .out_len_o        (out_len_o),
    .last_o           (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Result words cannot be stalled: every strobe seen at a rising edge is a
  // word taken and goes straight to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      sb.check_word(out_kind_o, out_seq_o, ctrl_counter_o, out_handle_o,
                    out_len_o, last_o);
    end
  end

  // Mostly legal lengths, sometimes anything 11 bits can hold (saturation).
  function automatic bit [LEN_W-1:0] pick_len();
    if ($urandom_range(0, 3) == 0) return LEN_W'($urandom_range(0, 2047));
    return LEN_W'($urandom_range(0, MAX_LEN));
  endfunction

  // Present one frame word at the falling edge and hold it until a rising
  // edge sees start high with busy low. Bursts of back-to-back words are
  // broken up by random gaps, zero-length gaps included.
  task automatic send_frame(input bit ok, input bit [TYPE_W-1:0] ftype,
                            input bit [SEQ_W-1:0] seq, input bit [HANDLE_W-1:0] handle,
                            input bit [LEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    start            <= 1'b1;
    checksum_ok_i    <= ok;
    frame_type_i     <= ftype;
    seq_num_i        <= seq;
    payload_handle_i <= handle;
    payload_len_i    <= len;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.take_frame(ok, ftype, seq, handle, len);
    if (ok && ftype == TYPE_DATA) data_frames++;
    else ignored_frames++;
    @(negedge clk_i);
  endtask

  // Hold the sender off until every predicted word has come out, then give a
  // frame that makes no words time to finish.
  task automatic settle();
    start <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // window_size is only written with the block idle.
  task automatic write_window(input bit [CFG_W-1:0] value);
    settle();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.window_reg = value;
  endtask

  // Window settings for the random phases: includes 0 (acts as 1), 1, the
  // full 16 and values above it (17, 31) that clamp to 16.
  int window_plan [10] = '{4, 1, 0, 8, 31, 5, 16, 17, 2, 12};

  initial begin
    bit [SEQ_W-1:0]    base;
    bit [SEQ_W-1:0]    seq;
    bit [TYPE_W-1:0]   ftype;
    bit                ok;
    int unsigned       span;
    int unsigned       pick;
    int                sent;

    sb = new();
    burst_left = 0;
    data_frames = 0;
    ignored_frames = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    checksum_ok_i = 1'b0;
    frame_type_i = '0;
    seq_num_i = '0;
    payload_handle_i = '0;
    payload_len_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part, reset window of 16 ----
    // frames the block must drop: bad checksum, and a non-data type
    send_frame(1'b0, TYPE_DATA, '0, '1, 11'd5);
    send_frame(1'b1, 8'hFF, '0, '0, '0);
    // in-order frames with field extremes; length 2047 saturates to 1400
    send_frame(1'b1, TYPE_DATA, 32'd0, '0, '0);
    send_frame(1'b1, TYPE_DATA, 32'd1, '1, 11'd2047);
    // old frame gets RR
    send_frame(1'b1, TYPE_DATA, 32'd0, 32'h1234_5678, 11'd1400);
    // two frames ahead: SREJ on the first, the repeat request is dropped,
    // then the missing frame flushes both and RR closes the walk
    send_frame(1'b1, TYPE_DATA, 32'd4, 32'hA5A5_5A5A, 11'd1401);
    send_frame(1'b1, TYPE_DATA, 32'd3, 32'h5A5A_A5A5, 11'd700);
    send_frame(1'b1, TYPE_DATA, 32'd2, 32'h0F0F_F0F0, 11'd1);
    // flush bound: sixteen frames ahead, the last one sharing the slot of
    // the expected frame; closing the gap gives 16 delivers and an SREJ
    base = sb.exp_seq;
    for (int k = 1; k <= SLOT_COUNT; k++) begin
      send_frame(1'b1, TYPE_DATA, base + SEQ_W'(k), $urandom(), pick_len());
    end
    send_frame(1'b1, TYPE_DATA, base, $urandom(), pick_len());

    // ---- random phases, one per window setting ----
    // Mostly the expected frame (which also fills holes), a share of frames
    // ahead by up to twice the window (so slots get overwritten), some old
    // frames, and some noise the block must ignore.
    foreach (window_plan[p]) begin
      write_window(CFG_W'(window_plan[p]));
      span = (window_plan[p] == 0) ? 1 :
             (window_plan[p] > SLOT_COUNT) ? SLOT_COUNT : window_plan[p];
      sent = 0;
      while (sent < PHASE_FRAMES) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          ftype = TYPE_W'($urandom_range(0, 255));
          ok    = 1'($urandom_range(0, 1));
          if (ok && ftype == TYPE_DATA) ok = 1'b0;
          send_frame(ok, ftype, $urandom(), $urandom(), pick_len());
        end else begin
          if (pick < 22 && sb.exp_seq != 0) seq = $urandom_range(0, sb.exp_seq - 1);
          else if (pick < 72) seq = sb.exp_seq;
          else seq = sb.exp_seq + SEQ_W'($urandom_range(1, 2 * span));
          send_frame(1'b1, TYPE_DATA, seq, $urandom(), pick_len());
          sent++;
        end
        // now and then let the block run completely dry mid-phase
        if ($urandom_range(0, 24) == 0) settle();
      end
    end

    // ---- top of the sequence space ----
    // An all-ones frame pins the highest sequence for good, so this goes
    // last; full-range sequences follow, mixed with the expected frame.
    write_window(WIN_RESET);
    send_frame(1'b1, TYPE_DATA, '1, $urandom(), pick_len());
    repeat (8) begin
      seq = ($urandom_range(0, 2) == 0) ? sb.exp_seq : $urandom();
      send_frame(1'b1, TYPE_DATA, seq, $urandom(), pick_len());
    end

    settle();
    $display("Run covered %0d data frames and %0d dropped frames over %0d window settings.",
             data_frames, ignored_frames, $size(window_plan) + 1);
    $display("%0d result words checked, %0d mismatches.", sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
